### rtl/rpv_pkg.sv
`timescale 1ns / 1ps

package rpv_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned MAXLEN_W = 12;
	localparam int unsigned COUNT_W = 13;
	localparam int unsigned PART_W  = 2;
	localparam int unsigned ADDR_W  = 2;
	localparam int unsigned DATA_W  = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(4096);
	localparam logic [PART_W-1:0]  PART_MAX  = '1;
	localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RESET = MAXLEN_W'(255);

	localparam logic [ADDR_W-1:0] REG_MAX_LENGTH = ADDR_W'(0);

	localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7F;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3F;
	localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
	localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_BAR    = 8'h7C;

	typedef struct packed {
		logic [COUNT_W-1:0] byte_count;
		logic [PART_W-1:0]  part_length;
		logic               part_all_dots;
		logic [BYTE_W-1:0]  previous_byte;
		logic               rejected_flag;
	} path_state_t;

	localparam path_state_t STATE_RESET = '{
		byte_count:    '0,
		part_length:   '0,
		part_all_dots: 1'b1,
		previous_byte: '0,
		rejected_flag: 1'b0
	};

	typedef struct packed {
		logic [BYTE_W-1:0] path_byte;
		logic              last;
		logic              empty_path;
	} path_item_t;

	typedef struct packed {
		logic               accepted;
		logic [COUNT_W-1:0] path_length;
	} verdict_t;

	function automatic logic bad_byte(input logic [BYTE_W-1:0] b);
		logic hit;
		hit = (b < CH_SPACE) || (b inside {CH_DEL, CH_BSLASH, CH_COLON, CH_STAR,
			CH_QMARK, CH_QUOTE, CH_LT, CH_GT, CH_BAR});
		return hit;
	endfunction

	// component that is closing now is empty, "." or "..", or ends in dot or space
	function automatic logic part_faulty(input path_state_t st);
		logic f;
		f = (st.part_length == '0)
			|| (st.part_all_dots && (st.part_length <= PART_W'(2)))
			|| (st.previous_byte == CH_DOT) || (st.previous_byte == CH_SPACE);
		return f;
	endfunction

endpackage

### rtl/rpv_if.sv
`timescale 1ns / 1ps

interface rpv_path_if;
	logic                      valid;
	logic                      ready;
	logic [rpv_pkg::BYTE_W-1:0] path_byte;
	logic                      last;
	logic                      empty_path;

	modport source (output valid, path_byte, last, empty_path, input ready);
	modport sink (input valid, path_byte, last, empty_path, output ready);
endinterface

interface rpv_verdict_if;
	logic                        valid;
	logic                        ready;
	logic                        accepted;
	logic [rpv_pkg::COUNT_W-1:0] path_length;

	modport source (output valid, accepted, path_length, input ready);
	modport sink (input valid, accepted, path_length, output ready);
endinterface

### rtl/relative_path_validator_unit.sv
`timescale 1ns / 1ps
// pipeline: a path byte is taken into the input register and checked there by rpv_step; the
// verdict for a last byte is held in the result register until the receiver takes it
// throughput: one byte per cycle, set by the single check stage after the input register;
// a verdict held back by the receiver stalls the input
// reset: arst_n clears the path state, the pipeline valid bits and sets max_length to 255

module relative_path_validator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	rpv_path_if.sink                     path,
	rpv_verdict_if.source                verdict,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rpv_pkg::ADDR_W-1:0]   paddr,
	input  logic [rpv_pkg::DATA_W-1:0]   pwdata,
	output logic [rpv_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import rpv_pkg::*;

	logic [MAXLEN_W-1:0] max_length_q;
	logic                valid_s1;
	path_item_t          item_s1;
	path_state_t         state_q;
	path_state_t         state_next;
	verdict_t            verdict_next;
	logic                out_valid_q;
	verdict_t            out_q;
	logic                advance;

	// configuration port
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr == REG_MAX_LENGTH) begin
			prdata = DATA_W'(max_length_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == REG_MAX_LENGTH)) begin
			max_length_q <= pwdata[MAXLEN_W-1:0];
		end
	end

	// result register frees up when empty or when its transfer completes
	assign advance    = !out_valid_q || verdict.ready;
	assign path.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (path.ready) begin
			valid_s1 <= path.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (path.ready && path.valid) begin
			item_s1.path_byte  <= path.path_byte;
			item_s1.last       <= path.last;
			item_s1.empty_path <= path.empty_path;
		end
	end

	rpv_step u_step (
		.st         (state_q),
		.item       (item_s1),
		.max_length (max_length_q),
		.st_next    (state_next),
		.verdict    (verdict_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			if (valid_s1) begin
				state_q <= state_next;
			end
			out_valid_q <= valid_s1 && item_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && item_s1.last) begin
			out_q <= verdict_next;
		end
	end

	assign verdict.valid       = out_valid_q;
	assign verdict.accepted    = out_q.accepted;
	assign verdict.path_length = out_q.path_length;

endmodule

### rtl/rpv_step.sv
`timescale 1ns / 1ps

module rpv_step (
	input  rpv_pkg::path_state_t           st,
	input  rpv_pkg::path_item_t            item,
	input  logic [rpv_pkg::MAXLEN_W-1:0]   max_length,
	output rpv_pkg::path_state_t           st_next,
	output rpv_pkg::verdict_t              verdict
);
	import rpv_pkg::*;

	path_state_t upd;
	logic        reject;

	always_comb begin
		upd = st;
		if (!item.empty_path) begin
			if (st.byte_count != COUNT_MAX) begin
				upd.byte_count = st.byte_count + COUNT_W'(1);
			end
			if (item.path_byte == CH_SLASH) begin
				if (part_faulty(st)) begin
					upd.rejected_flag = 1'b1;
				end
				upd.part_length   = '0;
				upd.part_all_dots = 1'b1;
			end else begin
				if (bad_byte(item.path_byte)) begin
					upd.rejected_flag = 1'b1;
				end
				if (st.part_length != PART_MAX) begin
					upd.part_length = st.part_length + PART_W'(1);
				end
				if (item.path_byte != CH_DOT) begin
					upd.part_all_dots = 1'b0;
				end
			end
			upd.previous_byte = item.path_byte;
		end
	end

	always_comb begin
		reject = upd.rejected_flag
			|| (upd.byte_count == '0)
			|| (upd.byte_count > {1'b0, max_length})
			|| part_faulty(upd);
		verdict.accepted    = !reject;
		verdict.path_length = upd.byte_count;
		st_next = item.last ? STATE_RESET : upd;
	end

endmodule
